FILE: rtl/core/obwc_pkg.sv
`default_nettype none
package obwc_pkg;

    localparam int MAX_WALLS = 64;
    localparam int WALL_AW = $clog2(MAX_WALLS);
    localparam int CNT_W = 7;

    localparam logic [0:0] ACT_WRITE = 1'b0;
    localparam logic [0:0] ACT_QUERY = 1'b1;

    typedef struct packed {
        logic [0:0]          action;
        logic [5:0]          wall_index;
        logic signed [23:0]  pos_x;
        logic signed [23:0]  pos_y;
        logic [23:0]         size_w;
        logic [23:0]         size_h;
        logic [15:0]         turn;
        logic signed [23:0]  center_x;
        logic signed [23:0]  center_y;
    } t_in_item;

    typedef struct packed {
        logic was_query;
        logic hit;
    } t_out_item;

    typedef struct packed {
        logic signed [23:0] x;
        logic signed [23:0] y;
        logic [23:0]        w;
        logic [23:0]        h;
        logic [15:0]        turn;
    } t_wall;

    typedef enum logic [2:0] {
        S_IDLE, S_READ, S_LOAD, S_MUL, S_DRAIN, S_SUM, S_CMP, S_DONE
    } t_state;

    typedef enum logic [4:0] {
        M_C2C0, M_S2S0, M_C2S0, M_S2C0,
        M_RXC0, M_RYS0, M_RYC0, M_RXS0,
        M_RXC2, M_RYS2, M_RYC2, M_RXS2,
        M_D20W, M_D30H, M_D30W, M_D20H,
        M_A0LO_D20, M_A0HI_D20, M_A1LO_D30, M_A1HI_D30,
        M_A0LO_D30, M_A0HI_D30, M_A1LO_D20, M_A1HI_D20
    } t_mstep;

    typedef struct packed {
        logic   issue;
        logic   clear;
        t_mstep step;
    } t_mac_ctl;

    typedef struct packed {
        logic signed [15:0] c0;
        logic signed [15:0] s0;
        logic signed [15:0] c2;
        logic signed [15:0] s2;
        logic signed [24:0] rx;
        logic signed [24:0] ry;
        logic [23:0]        ww;
        logic [23:0]        wh;
        logic signed [25:0] a0lo;
        logic signed [25:0] a0hi;
        logic signed [25:0] a1lo;
        logic signed [25:0] a1hi;
    } t_mac_ops;

    typedef struct packed {
        logic signed [63:0] b1;
        logic signed [63:0] b2;
        logic signed [63:0] b3;
        logic signed [63:0] b4;
        logic signed [63:0] s1;
        logic signed [63:0] s2;
        logic signed [63:0] lo3;
        logic signed [63:0] hi3;
        logic signed [63:0] lo4;
        logic signed [63:0] hi4;
    } t_mac_acc;

    localparam logic [14:0] QSINE [17] = '{
        15'd0, 15'd1606, 15'd3196, 15'd4756, 15'd6270, 15'd7723, 15'd9102,
        15'd10394, 15'd11585, 15'd12665, 15'd13623, 15'd14449, 15'd15137,
        15'd15679, 15'd16069, 15'd16305, 15'd16384
    };

    function automatic logic [14:0] qsin(input logic [14:0] u);
        logic [4:0]  i;
        logic [9:0]  f;
        logic [10:0] d;
        logic [20:0] p;
        i = u[14:10];
        f = u[9:0];
        d = '0;
        p = '0;
        if (i >= 5'd16) begin
            return QSINE[16];
        end
        d = 11'(QSINE[i + 5'd1] - QSINE[i]);
        p = 21'(d) * 21'(f);
        return 15'(QSINE[i] + 15'(p >> 10));
    endfunction

    function automatic logic signed [15:0] bsin(input logic [15:0] a);
        logic [14:0] p;
        logic [14:0] v;
        p = {1'b0, a[13:0]};
        v = '0;
        case (a[15:14])
            2'd0: v = qsin(p);
            2'd1: v = qsin(15'd16384 - p);
            2'd2: v = qsin(p);
            default: v = qsin(15'd16384 - p);
        endcase
        if (a[15]) begin
            return -signed'({1'b0, v});
        end
        return signed'({1'b0, v});
    endfunction

    function automatic logic signed [15:0] bcos(input logic [15:0] a);
        return bsin(16'(a + 16'd16384));
    endfunction

endpackage
`default_nettype wire

FILE: rtl/core/obwc_wall_mem.sv
`default_nettype none
module obwc_wall_mem (
    input  wire logic                          i_clk,
    input  wire logic                          i_we,
    input  wire logic [obwc_pkg::WALL_AW-1:0]  i_waddr,
    input  wire obwc_pkg::t_wall               i_wdata,
    input  wire logic                          i_re,
    input  wire logic [obwc_pkg::WALL_AW-1:0]  i_raddr,
    output obwc_pkg::t_wall                    o_rdata
);
    import obwc_pkg::*;

    t_wall mem [MAX_WALLS];
    t_wall r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

FILE: rtl/core/obwc_mac.sv
`default_nettype none
module obwc_mac (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire obwc_pkg::t_mac_ctl i_ctl,
    input  wire obwc_pkg::t_mac_ops i_ops,
    output obwc_pkg::t_mac_acc      o_acc
);
    import obwc_pkg::*;

    logic signed [31:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [63:0] r_prod;
    t_mstep             r_pstep;
    logic               r_pv;
    logic signed [63:0] r_d20;
    logic signed [63:0] r_d30;
    logic signed [31:0] mag20;
    logic signed [31:0] mag30;
    logic signed [31:0] e_c0, e_s0, e_c2, e_s2, e_rx, e_ry, e_ww, e_wh;
    logic signed [31:0] e_a0lo, e_a0hi, e_a1lo, e_a1hi, e_d20, e_d30;
    logic signed [63:0] dbl;
    logic               pos20;
    logic               pos30;
    logic               neg30;
    t_mac_acc           r_acc;

    assign e_c0   = {{16{i_ops.c0[15]}}, i_ops.c0};
    assign e_s0   = {{16{i_ops.s0[15]}}, i_ops.s0};
    assign e_c2   = {{16{i_ops.c2[15]}}, i_ops.c2};
    assign e_s2   = {{16{i_ops.s2[15]}}, i_ops.s2};
    assign e_rx   = {{7{i_ops.rx[24]}}, i_ops.rx};
    assign e_ry   = {{7{i_ops.ry[24]}}, i_ops.ry};
    assign e_ww   = {8'd0, i_ops.ww};
    assign e_wh   = {8'd0, i_ops.wh};
    assign e_a0lo = {{6{i_ops.a0lo[25]}}, i_ops.a0lo};
    assign e_a0hi = {{6{i_ops.a0hi[25]}}, i_ops.a0hi};
    assign e_a1lo = {{6{i_ops.a1lo[25]}}, i_ops.a1lo};
    assign e_a1hi = {{6{i_ops.a1hi[25]}}, i_ops.a1hi};
    assign e_d20  = r_d20[31:0];
    assign e_d30  = r_d30[31:0];
    assign mag20  = r_d20[63] ? -e_d20 : e_d20;
    assign mag30  = r_d30[63] ? -e_d30 : e_d30;
    assign pos20  = !r_d20[63] && (r_d20 != '0);
    assign pos30  = !r_d30[63] && (r_d30 != '0);
    assign neg30  = r_d30[63];
    assign dbl    = r_prod <<< 1;

    always_comb begin
        mul_a = e_c2;
        mul_b = e_c0;
        case (i_ctl.step)
            M_C2C0:     begin mul_a = e_c2;   mul_b = e_c0;  end
            M_S2S0:     begin mul_a = e_s2;   mul_b = e_s0;  end
            M_C2S0:     begin mul_a = e_c2;   mul_b = e_s0;  end
            M_S2C0:     begin mul_a = e_s2;   mul_b = e_c0;  end
            M_RXC0:     begin mul_a = e_rx;   mul_b = e_c0;  end
            M_RYS0:     begin mul_a = e_ry;   mul_b = e_s0;  end
            M_RYC0:     begin mul_a = e_ry;   mul_b = e_c0;  end
            M_RXS0:     begin mul_a = e_rx;   mul_b = e_s0;  end
            M_RXC2:     begin mul_a = e_rx;   mul_b = e_c2;  end
            M_RYS2:     begin mul_a = e_ry;   mul_b = e_s2;  end
            M_RYC2:     begin mul_a = e_ry;   mul_b = e_c2;  end
            M_RXS2:     begin mul_a = e_rx;   mul_b = e_s2;  end
            M_D20W:     begin mul_a = mag20;  mul_b = e_ww;  end
            M_D30H:     begin mul_a = mag30;  mul_b = e_wh;  end
            M_D30W:     begin mul_a = mag30;  mul_b = e_ww;  end
            M_D20H:     begin mul_a = mag20;  mul_b = e_wh;  end
            M_A0LO_D20: begin mul_a = e_a0lo; mul_b = e_d20; end
            M_A0HI_D20: begin mul_a = e_a0hi; mul_b = e_d20; end
            M_A1LO_D30: begin mul_a = e_a1lo; mul_b = e_d30; end
            M_A1HI_D30: begin mul_a = e_a1hi; mul_b = e_d30; end
            M_A0LO_D30: begin mul_a = e_a0lo; mul_b = e_d30; end
            M_A0HI_D30: begin mul_a = e_a0hi; mul_b = e_d30; end
            M_A1LO_D20: begin mul_a = e_a1lo; mul_b = e_d20; end
            M_A1HI_D20: begin mul_a = e_a1hi; mul_b = e_d20; end
            default:    begin mul_a = e_c2;   mul_b = e_c0;  end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod  <= mul_a * mul_b;
        r_pstep <= i_ctl.step;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_pv <= 1'b0;
        end else begin
            r_pv <= i_ctl.issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.clear) begin
            r_d20 <= '0;
            r_d30 <= '0;
            r_acc <= '0;
        end else if (r_pv) begin
            case (r_pstep)
                M_C2C0, M_S2S0: r_d20 <= r_d20 + r_prod;
                M_C2S0:         r_d30 <= r_d30 + r_prod;
                M_S2C0:         r_d30 <= r_d30 - r_prod;
                M_RXC0, M_RYS0: r_acc.b1 <= r_acc.b1 + r_prod;
                M_RYC0:         r_acc.b2 <= r_acc.b2 + r_prod;
                M_RXS0:         r_acc.b2 <= r_acc.b2 - r_prod;
                M_RXC2, M_RYS2: r_acc.b3 <= r_acc.b3 - r_prod;
                M_RYC2:         r_acc.b4 <= r_acc.b4 - r_prod;
                M_RXS2:         r_acc.b4 <= r_acc.b4 + r_prod;
                M_D20W, M_D30H: r_acc.s1 <= r_acc.s1 + r_prod;
                M_D30W, M_D20H: r_acc.s2 <= r_acc.s2 + r_prod;
                M_A0LO_D20: begin
                    if (pos20) r_acc.lo3 <= r_acc.lo3 + dbl;
                    else       r_acc.hi3 <= r_acc.hi3 + dbl;
                end
                M_A0HI_D20: begin
                    if (pos20) r_acc.hi3 <= r_acc.hi3 + dbl;
                    else       r_acc.lo3 <= r_acc.lo3 + dbl;
                end
                M_A1LO_D30: begin
                    if (neg30) r_acc.lo3 <= r_acc.lo3 - dbl;
                    else       r_acc.hi3 <= r_acc.hi3 - dbl;
                end
                M_A1HI_D30: begin
                    if (neg30) r_acc.hi3 <= r_acc.hi3 - dbl;
                    else       r_acc.lo3 <= r_acc.lo3 - dbl;
                end
                M_A0LO_D30: begin
                    if (pos30) r_acc.lo4 <= r_acc.lo4 + dbl;
                    else       r_acc.hi4 <= r_acc.hi4 + dbl;
                end
                M_A0HI_D30: begin
                    if (pos30) r_acc.hi4 <= r_acc.hi4 + dbl;
                    else       r_acc.lo4 <= r_acc.lo4 + dbl;
                end
                M_A1LO_D20: begin
                    if (pos20) r_acc.lo4 <= r_acc.lo4 + dbl;
                    else       r_acc.hi4 <= r_acc.hi4 + dbl;
                end
                M_A1HI_D20: begin
                    if (pos20) r_acc.hi4 <= r_acc.hi4 + dbl;
                    else       r_acc.lo4 <= r_acc.lo4 + dbl;
                end
                default: r_d20 <= r_d20;
            endcase
        end
    end

    assign o_acc = r_acc;
endmodule
`default_nettype wire

FILE: rtl/core/oriented_box_wall_collision.sv
`default_nettype none
// Wall table plus oriented-box collision query. A write item (action 0) stores one wall
// and is acknowledged from the done state via the output register. A query item
// (action 1) tests the box against walls 0 to min(wall_count, 64)-1 in order and stops
// at the first overlap; the single 32x32 multiplier forms the 24 products of each wall
// one per cycle. The next item is taken as soon as the result sits in the output
// register. Only write wall_count while idle, and only query walls that were written.
module oriented_box_wall_collision (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [6:0]            i_cfg_data,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire obwc_pkg::t_in_item    i_in_data,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output obwc_pkg::t_out_item        o_out_data
);
    import obwc_pkg::*;

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   r_n;
    logic [CNT_W-1:0]   r_idx;
    t_mstep             r_step;
    logic               r_hit;
    logic               r_was_query;
    logic               r_out_valid;
    t_out_item          r_out_data;
    logic signed [23:0] r_px, r_py;
    t_mac_ops           r_ops;
    t_wall              rd_wall;
    t_wall              wr_wall;
    t_mac_ctl           mac_ctl;
    t_mac_acc           acc;
    logic               accept;
    logic               out_free;
    logic               mem_we;
    logic               mem_re;
    logic               all_ov;
    logic signed [63:0] r_lo1, r_hi1, r_lo2, r_hi2, r_lo3, r_hi3, r_lo4, r_hi4;
    logic signed [63:0] a0lo_k, a0hi_k, a1lo_k, a1hi_k, half3, half4;

    assign accept   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign mem_we   = accept && (i_in_data.action == ACT_WRITE);
    assign mem_re   = (r_state == S_READ);

    assign wr_wall.x    = i_in_data.pos_x;
    assign wr_wall.y    = i_in_data.pos_y;
    assign wr_wall.w    = i_in_data.size_w;
    assign wr_wall.h    = i_in_data.size_h;
    assign wr_wall.turn = i_in_data.turn;

    obwc_wall_mem u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (i_in_data.wall_index[WALL_AW-1:0]),
        .i_wdata (wr_wall),
        .i_re    (mem_re),
        .i_raddr (r_idx[WALL_AW-1:0]),
        .o_rdata (rd_wall)
    );

    obwc_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mac_ctl),
        .i_ops   (r_ops),
        .o_acc   (acc)
    );

    assign a0lo_k = {{38{r_ops.a0lo[25]}}, r_ops.a0lo} <<< 29;
    assign a0hi_k = {{38{r_ops.a0hi[25]}}, r_ops.a0hi} <<< 29;
    assign a1lo_k = {{38{r_ops.a1lo[25]}}, r_ops.a1lo} <<< 29;
    assign a1hi_k = {{38{r_ops.a1hi[25]}}, r_ops.a1hi} <<< 29;
    assign half3  = {40'd0, r_ops.ww} <<< 28;
    assign half4  = {40'd0, r_ops.wh} <<< 28;

    assign all_ov = !(a0hi_k < r_lo1 || r_hi1 < a0lo_k)
                 && !(a1hi_k < r_lo2 || r_hi2 < a1lo_k)
                 && !(half3 < r_lo3 || r_hi3 < -half3)
                 && !(half4 < r_lo4 || r_hi4 < -half4);

    always_comb begin
        n_state       = r_state;
        mac_ctl.issue = 1'b0;
        mac_ctl.clear = 1'b0;
        mac_ctl.step  = r_step;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_in_data.action == ACT_WRITE || r_count == '0) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_READ;
                    end
                end
            end
            S_READ: n_state = S_LOAD;
            S_LOAD: begin
                mac_ctl.clear = 1'b1;
                n_state = S_MUL;
            end
            S_MUL: begin
                mac_ctl.issue = 1'b1;
                if (r_step == M_A1HI_D20) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: n_state = S_SUM;
            S_SUM:   n_state = S_CMP;
            S_CMP: begin
                if (all_ov || (r_idx + 7'd1) >= r_n) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_READ;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cfg_we) begin
            r_count <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx  <= '0;
            r_step <= M_C2C0;
            r_hit  <= 1'b0;
            r_n    <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    r_idx  <= '0;
                    r_hit  <= 1'b0;
                    r_n    <= (r_count > CNT_W'(MAX_WALLS)) ? CNT_W'(MAX_WALLS) : r_count;
                end
                S_LOAD: r_step <= M_C2C0;
                S_MUL: begin
                    if (r_step != M_A1HI_D20) begin
                        r_step <= t_mstep'(r_step + 5'd1);
                    end
                end
                S_CMP: begin
                    r_hit <= all_ov;
                    r_idx <= r_idx + 7'd1;
                end
                default: r_idx <= r_idx;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && accept) begin
            r_px      <= i_in_data.pos_x;
            r_py      <= i_in_data.pos_y;
            r_ops.c0  <= bcos(i_in_data.turn);
            r_ops.s0  <= bsin(i_in_data.turn);
            r_ops.a0lo <= -{{2{i_in_data.center_x[23]}}, i_in_data.center_x};
            r_ops.a0hi <= {2'b00, i_in_data.size_w}
                        - {{2{i_in_data.center_x[23]}}, i_in_data.center_x};
            r_ops.a1lo <= -{{2{i_in_data.center_y[23]}}, i_in_data.center_y};
            r_ops.a1hi <= {2'b00, i_in_data.size_h}
                        - {{2{i_in_data.center_y[23]}}, i_in_data.center_y};
        end
        if (r_state == S_LOAD) begin
            r_ops.c2 <= bcos(rd_wall.turn);
            r_ops.s2 <= bsin(rd_wall.turn);
            r_ops.rx <= {rd_wall.x[23], rd_wall.x} - {r_px[23], r_px};
            r_ops.ry <= {rd_wall.y[23], rd_wall.y} - {r_py[23], r_py};
            r_ops.ww <= rd_wall.w;
            r_ops.wh <= rd_wall.h;
        end
        if (r_state == S_SUM) begin
            r_lo1 <= (acc.b1 <<< 15) - acc.s1;
            r_hi1 <= (acc.b1 <<< 15) + acc.s1;
            r_lo2 <= (acc.b2 <<< 15) - acc.s2;
            r_hi2 <= (acc.b2 <<< 15) + acc.s2;
            r_lo3 <= (acc.b3 <<< 15) + acc.lo3;
            r_hi3 <= (acc.b3 <<< 15) + acc.hi3;
            r_lo4 <= (acc.b4 <<< 15) + acc.lo4;
            r_hi4 <= (acc.b4 <<< 15) + acc.hi4;
        end
    end

    // result register, loaded when the done state hands over
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_DONE && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && accept) begin
            r_was_query <= (i_in_data.action == ACT_QUERY);
        end
        if (r_state == S_DONE && out_free) begin
            r_out_data.was_query <= r_was_query;
            r_out_data.hit       <= r_hit && r_was_query;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    a_walk_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL) |-> (r_idx < r_n))
        else $error("wall walk past the tested count");

    a_ack_no_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.was_query) |-> !o_out_data.hit)
        else $error("write acknowledge reports a hit");

    a_done_delivers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && out_free) |=> (o_out_valid && r_state == S_IDLE))
        else $error("finished item not presented");

    a_busy_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL || r_state == S_CMP) |-> o_in_stall)
        else $error("input open during a query");

endmodule
`default_nettype wire

FILE: verif/testbench.sv
module testbench;
    import obwc_pkg::*;

    localparam int CYCLE_LIMIT = 4000000;
    localparam int HOLD_CYCLES = 3000;
    localparam int SETTLE = 8;
    localparam longint QTABLE [17] = '{
        0, 1606, 3196, 4756, 6270, 7723, 9102, 10394, 11585,
        12665, 13623, 14449, 15137, 15679, 16069, 16305, 16384
    };

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_we = 1'b0;
    logic [6:0] i_cfg_data = '0;
    logic       i_in_valid = 1'b0;
    logic       o_in_stall;
    t_in_item   i_in_data = '0;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    t_out_item  o_out_data;

    oriented_box_wall_collision dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    t_in_item  pending_items[$];
    t_out_item expected_results[$];
    longint    wall_x[64], wall_y[64], wall_w[64], wall_h[64];
    int        wall_turn[64];
    int        tested_walls = 0;
    int        mismatches = 0;
    int        cycle_count = 0;
    int        hold_left = 0;
    bit        hold_armed = 0;
    bit        hold_done = 0;
    logic      calm;

    assign calm = (cycle_count % 40000) < 8000;

    function automatic longint quarter_sin(int u);
        int i;
        longint f;
        i = u >> 10;
        f = u & 1023;
        if (i >= 16) begin
            return QTABLE[16];
        end
        return QTABLE[i] + (((QTABLE[i + 1] - QTABLE[i]) * f) >>> 10);
    endfunction

    function automatic longint angle_sin(int a);
        int p;
        p = a & 16'h3FFF;
        case ((a >> 14) & 3)
            0: return quarter_sin(p);
            1: return quarter_sin(16384 - p);
            2: return -quarter_sin(p);
            default: return -quarter_sin(16384 - p);
        endcase
    endfunction

    function automatic longint angle_cos(int a);
        return angle_sin((a + 16384) & 16'hFFFF);
    endfunction

    function automatic longint absval(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic bit spans_touch(longint alo, longint ahi, longint blo, longint bhi);
        return !(ahi < blo || bhi < alo);
    endfunction

    function automatic bit box_on_wall_axis(longint base, longint da, longint db,
                                            longint alo, longint ahi, longint blo,
                                            longint bhi, longint half);
        longint lo, hi;
        lo = base;
        hi = base;
        if (da > 0) begin
            lo += 2 * alo * da;
            hi += 2 * ahi * da;
        end else begin
            lo += 2 * ahi * da;
            hi += 2 * alo * da;
        end
        if (db > 0) begin
            lo += 2 * blo * db;
            hi += 2 * bhi * db;
        end else begin
            lo += 2 * bhi * db;
            hi += 2 * blo * db;
        end
        return spans_touch(-half, half, lo, hi);
    endfunction

    function automatic bit box_hits_walls(t_in_item it);
        longint k, c0, s0, c2, s2, px, py, a0lo, a0hi, a1lo, a1hi;
        longint rx, ry, d20, d30, d21, d31, base, spread;
        int n;
        k = 64'sd1 << 29;
        c0 = angle_cos(int'(it.turn));
        s0 = angle_sin(int'(it.turn));
        px = longint'($signed(it.pos_x));
        py = longint'($signed(it.pos_y));
        a0lo = -longint'($signed(it.center_x));
        a0hi = longint'(it.size_w) + a0lo;
        a1lo = -longint'($signed(it.center_y));
        a1hi = longint'(it.size_h) + a1lo;
        n = tested_walls < 64 ? tested_walls : 64;
        for (int i = 0; i < n; i++) begin
            c2 = angle_cos(wall_turn[i]);
            s2 = angle_sin(wall_turn[i]);
            rx = wall_x[i] - px;
            ry = wall_y[i] - py;
            d20 = c2 * c0 + s2 * s0;
            d30 = c2 * s0 - s2 * c0;
            d21 = s2 * c0 - c2 * s0;
            d31 = s2 * s0 + c2 * c0;
            base = (rx * c0 + ry * s0) * 32768;
            spread = absval(d20) * wall_w[i] + absval(d30) * wall_h[i];
            if (!spans_touch(a0lo * k, a0hi * k, base - spread, base + spread)) continue;
            base = (ry * c0 - rx * s0) * 32768;
            spread = absval(d21) * wall_w[i] + absval(d31) * wall_h[i];
            if (!spans_touch(a1lo * k, a1hi * k, base - spread, base + spread)) continue;
            base = -(rx * c2 + ry * s2) * 32768;
            if (!box_on_wall_axis(base, d20, d21, a0lo, a0hi, a1lo, a1hi,
                                  wall_w[i] * (k / 2))) continue;
            base = -(ry * c2 - rx * s2) * 32768;
            if (box_on_wall_axis(base, d30, d31, a0lo, a0hi, a1lo, a1hi,
                                 wall_h[i] * (k / 2))) return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic t_out_item predict_answer(t_in_item it);
        t_out_item r;
        r = '0;
        if (it.action == ACT_WRITE) begin
            wall_x[it.wall_index] = longint'($signed(it.pos_x));
            wall_y[it.wall_index] = longint'($signed(it.pos_y));
            wall_w[it.wall_index] = longint'(it.size_w);
            wall_h[it.wall_index] = longint'(it.size_h);
            wall_turn[it.wall_index] = int'(it.turn);
        end else begin
            r.was_query = 1'b1;
            r.hit = box_hits_walls(it);
        end
        return r;
    endfunction

    function automatic logic [23:0] near(int reach);
        return 24'(int'($urandom_range(2 * reach)) - reach);
    endfunction

    function automatic t_in_item make_wall(int idx, bit wide);
        t_in_item it;
        it = '0;
        it.action = ACT_WRITE;
        it.wall_index = 6'(idx);
        it.turn = 16'($urandom);
        it.center_x = 24'($urandom);
        it.center_y = 24'($urandom);
        if (wide) begin
            it.pos_x = 24'($urandom);
            it.pos_y = 24'($urandom);
            it.size_w = 24'($urandom);
            it.size_h = 24'($urandom);
        end else begin
            it.pos_x = near(40 * 256);
            it.pos_y = near(40 * 256);
            it.size_w = 24'($urandom_range(20 * 256));
            it.size_h = 24'($urandom_range(20 * 256));
        end
        return it;
    endfunction

    function automatic t_in_item make_box(bit wide);
        t_in_item it;
        it = '0;
        it.action = ACT_QUERY;
        it.wall_index = 6'($urandom);
        it.turn = 16'($urandom);
        if (wide) begin
            it.pos_x = 24'($urandom);
            it.pos_y = 24'($urandom);
            it.size_w = 24'($urandom);
            it.size_h = 24'($urandom);
            it.center_x = 24'($urandom);
            it.center_y = 24'($urandom);
        end else begin
            it.pos_x = near(50 * 256);
            it.pos_y = near(50 * 256);
            it.size_w = 24'($urandom_range(30 * 256));
            it.size_h = 24'($urandom_range(30 * 256));
            if ($urandom_range(9) == 0) begin
                it.center_x = near(40 * 256);
                it.center_y = near(40 * 256);
            end else begin
                it.center_x = 24'($urandom_range(int'(it.size_w)));
                it.center_y = 24'($urandom_range(int'(it.size_h)));
            end
        end
        return it;
    endfunction

    task automatic add_item(t_in_item it);
        pending_items = {pending_items, it};
    endtask

    // input side
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                expected_results = {expected_results, predict_answer(i_in_data)};
            end
            if (!i_in_valid || !o_in_stall) begin
                if (pending_items.size() > 0 && (calm || $urandom_range(99) >= 30)) begin
                    i_in_valid <= 1'b1;
                    i_in_data <= pending_items.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off
    always @(posedge i_clk) begin
        if (hold_armed && !hold_done) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // output side
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected item: was_query %0b hit %0b",
                             o_out_data.was_query, o_out_data.hit);
                end
            end else begin
                want = expected_results.pop_front();
                if (o_out_data.was_query !== want.was_query || o_out_data.hit !== want.hit) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("item mismatch: expected was_query %0b hit %0b, got %0b %0b",
                                 want.was_query, want.hit,
                                 o_out_data.was_query, o_out_data.hit);
                    end
                end
            end
        end
        i_out_stall <= (hold_left > 1) || (!calm && $urandom_range(99) < 30);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_items.size() > 0 || i_in_valid || expected_results.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_wall_count(int value);
        wait_drained();
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= 7'(value);
        tested_walls = value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        int counts [10] = '{1, 127, 3, 0, 64, 5, 2, 8, 4, 1};
        t_in_item it;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // zero count answers no hit
        add_item(make_box(1'b0));
        add_item(make_box(1'b1));
        for (int i = 0; i < 64; i++) begin
            add_item(make_wall(i, 1'b0));
        end
        set_wall_count(64);

        // field extremes and axis-aligned angles
        it = make_wall(63, 1'b0);
        it.turn = 16'hFFFF;
        add_item(it);
        it = make_wall(62, 1'b0);
        it.pos_x = 24'h800000;
        it.pos_y = 24'h7FFFFF;
        it.size_w = 24'hFFFFFF;
        it.size_h = '0;
        it.turn = '0;
        add_item(it);
        for (int a = 0; a < 5; a++) begin
            it = make_box(1'b0);
            it.turn = (a == 4) ? 16'hFFFF : 16'(a * 16384);
            add_item(it);
        end
        it = make_box(1'b0);
        it.pos_x = 24'h7FFFFF;
        it.pos_y = 24'h800000;
        it.size_w = '0;
        it.size_h = 24'hFFFFFF;
        it.center_x = 24'h800000;
        it.center_y = 24'h7FFFFF;
        add_item(it);
        it = make_box(1'b0);
        it.size_w = '0;
        it.size_h = '0;
        it.center_x = 24'h7FFFFF;
        it.center_y = 24'h800000;
        add_item(it);
        it = make_box(1'b0);
        it.pos_x = '0;
        it.pos_y = '0;
        it.size_w = 24'hFFFFFF;
        it.size_h = 24'hFFFFFF;
        it.center_x = 24'h7FFFFF;
        it.center_y = 24'h7FFFFF;
        add_item(it);

        set_wall_count(1);
        // write-heavy burst while the receiver holds off
        for (int i = 0; i < 30; i++) begin
            add_item(make_wall($urandom_range(1, 63), $urandom_range(9) == 0));
        end
        add_item(make_box(1'b0));
        hold_armed = 1'b1;

        foreach (counts[p]) begin
            set_wall_count(counts[p]);
            for (int i = 0; i < 30; i++) begin
                if ($urandom_range(3) == 0) begin
                    add_item(make_wall($urandom_range(63), $urandom_range(9) == 0));
                end else begin
                    add_item(make_box($urandom_range(9) == 0));
                end
            end
        end

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
